FILE: src/script_line_tokenizer_top_macros.svh
`ifndef SCRIPT_LINE_TOKENIZER_TOP_MACROS_SVH
`define SCRIPT_LINE_TOKENIZER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SLT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/slt_pkg.sv
package slt_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CountW     = $clog2(QueueDepth + 1);

  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChHyphen = 8'h2D;
  localparam logic [7:0] ChUnder  = 8'h5F;

  typedef enum logic [1:0] {
    ST_READY   = 2'd0,
    ST_WORD    = 2'd1,
    ST_STRING  = 2'd2,
    ST_COMMENT = 2'd3
  } scan_state_e;

  typedef enum logic [1:0] {
    EV_CHAR     = 2'd0,
    EV_DONE     = 2'd1,
    EV_ABANDON  = 2'd2,
    EV_LINE_END = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    KIND_NUMBER = 2'd0,
    KIND_IDENT  = 2'd1,
    KIND_STRING = 2'd2
  } token_kind_e;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] out_char;
    logic [1:0] token_kind;
    logic       last_of_run;
  } result_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return is_digit(c) || is_letter(c);
  endfunction

  function automatic result_t mk_res(logic [1:0] ev, logic [7:0] ch, logic [1:0] kind);
    result_t r;
    r.event_res   = ev;
    r.out_char    = ch;
    r.token_kind  = kind;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

FILE: src/script_line_tokenizer_top.sv
// Script line tokenizer.
// Input channel (in_valid_i / in_stall_o): one word per item, either a script
// character (mode_i = 0, char_code_i) or an end-of-line event (mode_i = 1).
// Output channel (out_valid_o / out_stall_i): one result word per transfer:
// token character, token complete with its kind, string abandoned, or line
// end; last_of_run_o flags the final result of an input item.
// An item is scanned in the cycle it is accepted and its zero, one or two
// results are written into a 4-entry result queue; the output is driven
// from the head of that registered queue. The scanner takes one item every
// cycle as long as the queue has room for two results, so a stream of
// items with at most one result each runs at one item per cycle; items
// with two results drain one word per transfer; the queue sets that pace.
// When the receiver stalls, the queue holds its head word steady and
// in_stall_o rises once fewer than two entries are free.
// Reset empties the queue and returns the scanner to ready, outside any
// word or string.
`include "script_line_tokenizer_top_macros.svh"

module script_line_tokenizer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [7:0] char_code_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] event_res_o,
  output logic [7:0] out_char_o,
  output logic [1:0] token_kind_o,
  output logic       last_of_run_o
);

  slt_pkg::scan_state_e st_q, st_d;
  logic quote_q, quote_d;
  logic hyph_q, hyph_d;
  logic ident_q, ident_d;
  logic empty_q, empty_d;

  slt_pkg::result_t res [2];
  logic [1:0] n;
  logic       ready_go;
  logic [1:0] kind_word;

  logic in_acc, pop;
  logic [1:0] push_n;

  slt_pkg::result_t mem_q [slt_pkg::QueueDepth];
  logic [slt_pkg::PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [slt_pkg::CountW-1:0] count_q;

  assign kind_word = ident_q ? slt_pkg::KIND_IDENT : slt_pkg::KIND_NUMBER;

  always_comb begin
    st_d     = st_q;
    quote_d  = quote_q;
    hyph_d   = hyph_q;
    ident_d  = ident_q;
    empty_d  = empty_q;
    res[0]   = '0;
    res[1]   = '0;
    n        = 2'd0;
    ready_go = 1'b0;
    if (mode_i) begin
      if (st_q == slt_pkg::ST_WORD) begin
        res[0] = slt_pkg::mk_res(slt_pkg::EV_DONE, 8'h00, kind_word);
        n = 2'd1;
      end else if (st_q == slt_pkg::ST_STRING) begin
        if (quote_q) begin
          res[0] = slt_pkg::mk_res(slt_pkg::EV_DONE, 8'h00, slt_pkg::KIND_STRING);
        end else begin
          res[0] = slt_pkg::mk_res(slt_pkg::EV_ABANDON, 8'h00, slt_pkg::KIND_NUMBER);
        end
        n = 2'd1;
      end
      res[n[0]] = slt_pkg::mk_res(slt_pkg::EV_LINE_END, 8'h00, slt_pkg::KIND_NUMBER);
      n = n + 2'd1;
      st_d    = slt_pkg::ST_READY;
      quote_d = 1'b0;
      hyph_d  = 1'b0;
      ident_d = 1'b0;
      empty_d = 1'b1;
    end else begin
      case (st_q)
        slt_pkg::ST_READY: begin
          ready_go = 1'b1;
        end
        slt_pkg::ST_WORD: begin
          if (hyph_q) begin
            hyph_d = 1'b0;
            if (slt_pkg::is_alnum(char_code_i) || char_code_i == slt_pkg::ChUnder) begin
              ident_d = 1'b1;
              res[0] = slt_pkg::mk_res(slt_pkg::EV_CHAR, slt_pkg::ChHyphen,
                                       slt_pkg::KIND_NUMBER);
              res[1] = slt_pkg::mk_res(slt_pkg::EV_CHAR, char_code_i, slt_pkg::KIND_NUMBER);
              n = 2'd2;
            end else begin
              // held hyphen dropped, word closes, char rescanned as ready
              res[0]   = slt_pkg::mk_res(slt_pkg::EV_DONE, 8'h00, kind_word);
              n        = 2'd1;
              st_d     = slt_pkg::ST_READY;
              ready_go = 1'b1;
            end
          end else if (slt_pkg::is_digit(char_code_i)) begin
            res[0] = slt_pkg::mk_res(slt_pkg::EV_CHAR, char_code_i, slt_pkg::KIND_NUMBER);
            n = 2'd1;
          end else if (slt_pkg::is_letter(char_code_i) || char_code_i == slt_pkg::ChUnder) begin
            ident_d = 1'b1;
            res[0] = slt_pkg::mk_res(slt_pkg::EV_CHAR, char_code_i, slt_pkg::KIND_NUMBER);
            n = 2'd1;
          end else if (char_code_i == slt_pkg::ChHyphen) begin
            hyph_d = 1'b1;
          end else begin
            res[0]   = slt_pkg::mk_res(slt_pkg::EV_DONE, 8'h00, kind_word);
            n        = 2'd1;
            st_d     = slt_pkg::ST_READY;
            ready_go = 1'b1;
          end
        end
        slt_pkg::ST_STRING: begin
          if (!quote_q) begin
            if (char_code_i == slt_pkg::ChQuote) begin
              quote_d = 1'b1;
            end else begin
              empty_d = 1'b0;
              res[0] = slt_pkg::mk_res(slt_pkg::EV_CHAR, char_code_i, slt_pkg::KIND_NUMBER);
              n = 2'd1;
            end
          end else if (char_code_i == slt_pkg::ChQuote ||
                       (empty_q && slt_pkg::is_alnum(char_code_i))) begin
            // doubled quote, or stray quote at the head of the string
            quote_d = 1'b0;
            empty_d = 1'b0;
            res[0] = slt_pkg::mk_res(slt_pkg::EV_CHAR, char_code_i, slt_pkg::KIND_NUMBER);
            n = 2'd1;
          end else begin
            res[0]   = slt_pkg::mk_res(slt_pkg::EV_DONE, 8'h00, slt_pkg::KIND_STRING);
            n        = 2'd1;
            quote_d  = 1'b0;
            empty_d  = 1'b1;
            st_d     = slt_pkg::ST_READY;
            ready_go = 1'b1;
          end
        end
        default: begin
          // comment: rest of line ignored
        end
      endcase
    end

    if (ready_go) begin
      if (char_code_i == slt_pkg::ChSemi) begin
        st_d = slt_pkg::ST_COMMENT;
      end else if (char_code_i == slt_pkg::ChQuote) begin
        st_d    = slt_pkg::ST_STRING;
        quote_d = 1'b0;
        empty_d = 1'b1;
      end else if (slt_pkg::is_alnum(char_code_i)) begin
        st_d    = slt_pkg::ST_WORD;
        hyph_d  = 1'b0;
        ident_d = slt_pkg::is_letter(char_code_i);
        res[n[0]] = slt_pkg::mk_res(slt_pkg::EV_CHAR, char_code_i, slt_pkg::KIND_NUMBER);
        n = n + 2'd1;
      end
    end

    if (n == 2'd2) begin
      res[1].last_of_run = 1'b1;
    end else if (n == 2'd1) begin
      res[0].last_of_run = 1'b1;
    end
  end

  assign in_acc = in_valid_i && !in_stall_o;
  assign pop    = out_valid_o && !out_stall_i;
  assign push_n = in_acc ? n : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= slt_pkg::ST_READY;
      quote_q <= 1'b0;
      hyph_q  <= 1'b0;
      ident_q <= 1'b0;
      empty_q <= 1'b1;
    end else if (in_acc) begin
      st_q    <= st_d;
      quote_q <= quote_d;
      hyph_q  <= hyph_d;
      ident_q <= ident_d;
      empty_q <= empty_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + slt_pkg::PtrW'(push_n);
      rd_ptr_q <= rd_ptr_q + slt_pkg::PtrW'(pop);
      count_q  <= count_q + slt_pkg::CountW'(push_n) - slt_pkg::CountW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_ptr_q] <= res[0];
    end
    if (push_n == 2'd2) begin
      mem_q[wr_ptr_q + slt_pkg::PtrW'(1)] <= res[1];
    end
  end

  // room for a full two-word run is required before taking an item
  assign in_stall_o    = count_q > slt_pkg::CountW'(slt_pkg::QueueDepth - 2);
  assign out_valid_o   = count_q != '0;
  assign event_res_o   = mem_q[rd_ptr_q].event_res;
  assign out_char_o    = mem_q[rd_ptr_q].out_char;
  assign token_kind_o  = mem_q[rd_ptr_q].token_kind;
  assign last_of_run_o = mem_q[rd_ptr_q].last_of_run;

  `SLT_ASSERT_IMP(a_queue_bound, 1'b1, count_q <= slt_pkg::CountW'(slt_pkg::QueueDepth),
    "result queue overflow")
  `SLT_ASSERT_NXT(a_line_end_clears, in_acc && mode_i,
    st_q == slt_pkg::ST_READY && !quote_q && !hyph_q && !ident_q && empty_q,
    "scanner state not cleared after line end")
  `SLT_ASSERT_IMP(a_line_end_last, out_valid_o && event_res_o == slt_pkg::EV_LINE_END,
    last_of_run_o, "line end word not marked last")
  `SLT_ASSERT_IMP(a_comment_silent, in_acc && !mode_i && st_q == slt_pkg::ST_COMMENT,
    push_n == 2'd0, "result produced inside comment")

endmodule
